// ===== src/tcf_pkg.sv =====
// ============================================================================
// tcf_pkg: shared types and constants of the tilt complementary filter
// Word layouts, fixed-point widths, register indexes and the CORDIC arctangent
// table in Q16 of 1/128 degree.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

  // Raw sensor axis width and the widened operand for atan2
  localparam int AXIS_W = 16;
  localparam int OPND_W = AXIS_W + 1;

  // CORDIC datapath: x/y hold counts scaled by 2^16 plus gain headroom
  localparam int CX_W  = 35;
  localparam int ANG_W = 33;

  // Arctangent table depth and the counter that walks it
  localparam int ATAN_DEPTH = 24;
  localparam int CNT_W      = $clog2(ATAN_DEPTH);
  localparam int ATAN_W     = 29;

  // Quarter turn in Q16 of 1/128 degree
  localparam logic signed [ANG_W-1:0] ANG_90 = 33'sd754974720;

  // Estimate and arithmetic widths
  localparam int EST_W  = 32;
  localparam int SUM_W  = EST_W + 1;
  localparam int YAW_W  = EST_W + 2;
  localparam int MA_W   = 34;
  localparam int MB_W   = 25;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 52;
  localparam int FRAC_W = 16;

  // Full turn of yaw in Q16 of 1/128 degree, and in output units
  localparam logic signed [YAW_W-1:0] YAW_FULL = 34'sd3019898880;
  localparam logic [15:0]             YAW_TURN = 16'd46080;

  // Blend rounding constant and unity gain
  localparam logic signed [ACC_W-1:0] BLEND_RND = 52'sd32768;
  localparam logic [FRAC_W:0]         ALPHA_ONE = 17'd65536;

  // Configuration registers
  localparam int IDX_W  = 1;
  localparam int CFG_W  = 24;
  localparam logic [IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [IDX_W-1:0] CFG_GAIN  = 1'b1;
  localparam logic [15:0] ALPHA_RST = 16'd64225;
  localparam logic [23:0] GAIN_RST  = 24'd147539;

  // Request kinds
  localparam logic REQ_SAMPLE    = 1'b0;
  localparam logic REQ_YAW_RESET = 1'b1;

  // Small queues between front, back and the result side
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                     req_type;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
  } tcf_in_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic        [15:0] yaw_angle;
  } tcf_out_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                     yaw_reset;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
  } tcf_cmd_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [23:0] gain;
  } tcf_cfg_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] y;
    logic signed [OPND_W-1:0] x;
  } tcf_cord_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } tcf_cord_rsp_t;

  // atan(2^-i) in Q16 of 1/128 degree, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 29'd377487360;
      5'd1:    v = 29'd222843801;
      5'd2:    v = 29'd117744544;
      5'd3:    v = 29'd59768969;
      5'd4:    v = 29'd30000467;
      5'd5:    v = 29'd15014858;
      5'd6:    v = 29'd7509261;
      5'd7:    v = 29'd3754860;
      5'd8:    v = 29'd1877459;
      5'd9:    v = 29'd938733;
      5'd10:   v = 29'd469367;
      5'd11:   v = 29'd234683;
      5'd12:   v = 29'd117342;
      5'd13:   v = 29'd58671;
      5'd14:   v = 29'd29335;
      5'd15:   v = 29'd14668;
      5'd16:   v = 29'd7334;
      5'd17:   v = 29'd3667;
      5'd18:   v = 29'd1833;
      5'd19:   v = 29'd917;
      5'd20:   v = 29'd458;
      5'd21:   v = 29'd229;
      5'd22:   v = 29'd115;
      5'd23:   v = 29'd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/tcf_front.sv =====
// ============================================================================
// tcf_front: input side of the filter
// Accepts words from the input queue port, classifies them as sensor sample
// or yaw reset, and holds them in a two-entry queue for the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcf_front import tcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  tcf_in_t  sample,
  output logic     cmd_valid,
  output tcf_cmd_t cmd,
  input  logic     cmd_pop
);

  tcf_cmd_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                accept;
  logic                take;
  tcf_cmd_t            cls;

  // Classify the incoming word
  always_comb begin
    cls.yaw_reset = (sample.req_type == REQ_YAW_RESET);
    cls.accel_x   = sample.accel_x;
    cls.accel_y   = sample.accel_y;
    cls.accel_z   = sample.accel_z;
    cls.gyro_x    = sample.gyro_x;
    cls.gyro_y    = sample.gyro_y;
    cls.gyro_z    = sample.gyro_z;
  end

  assign full      = (count == QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign accept    = push && !full;
  assign take      = cmd_pop && cmd_valid;
  assign cmd       = mem[rd_ptr];

  // Store accepted words
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tcf_cordic.sv =====
// ============================================================================
// tcf_cordic: iterative vectoring CORDIC
// Computes atan2(y, x) in Q16 of 1/128 degree, one micro-rotation per cycle
// after a quadrant pre-rotation for negative x.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcf_cordic import tcf_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  tcf_cord_req_t req,
  output tcf_cord_rsp_t rsp
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic signed [CX_W-1:0]  x;
  logic signed [CX_W-1:0]  y;
  logic signed [ANG_W-1:0] z;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    done;

  logic signed [CX_W-1:0]  x0;
  logic signed [CX_W-1:0]  y0;
  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [ANG_W-1:0] step;

  // Scale operands by 2^16 and form the shifted terms of this step
  always_comb begin
    x0   = {{(CX_W - OPND_W - FRAC_W){req.x[OPND_W-1]}}, req.x, {FRAC_W{1'b0}}};
    y0   = {{(CX_W - OPND_W - FRAC_W){req.y[OPND_W-1]}}, req.y, {FRAC_W{1'b0}}};
    xs   = x >>> cnt;
    ys   = y >>> cnt;
    step = signed'(ANG_W'(atan_entry(cnt)));
  end

  // Pre-rotate on start, then rotate toward y = 0
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (x0[CX_W-1]) begin
        if (!y0[CX_W-1]) begin
          x <= y0;
          y <= -x0;
          z <= ANG_90;
        end else begin
          x <= -y0;
          y <= x0;
          z <= -ANG_90;
        end
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[CX_W-1] && (y != '0)) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step;
      end else if (y[CX_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step;
      end
    end
  end

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.angle = z;

endmodule

`default_nettype wire

// ===== src/tcf_back.sv =====
// ============================================================================
// tcf_back: execution side of the filter
// Sequences the two CORDIC angles, the gyro increments and the blends over a
// shared multiplier, updates the estimates and queues result words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcf_back import tcf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  tcf_cfg_t      cfg,
  input  logic          cmd_valid,
  input  tcf_cmd_t      cmd,
  output logic          cmd_pop,
  output tcf_cord_req_t cord_req,
  input  tcf_cord_rsp_t cord_rsp,
  output logic          empty,
  input  logic          pop,
  output tcf_out_t      result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CORD_P = 4'd1;
  localparam logic [3:0] S_CORD_R = 4'd2;
  localparam logic [3:0] S_INC_X  = 4'd3;
  localparam logic [3:0] S_INC_Y  = 4'd4;
  localparam logic [3:0] S_INC_Z  = 4'd5;
  localparam logic [3:0] S_PA     = 4'd6;
  localparam logic [3:0] S_PB     = 4'd7;
  localparam logic [3:0] S_PC     = 4'd8;
  localparam logic [3:0] S_RB     = 4'd9;
  localparam logic [3:0] S_RC     = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0]               state;
  tcf_cmd_t                 cur;
  logic signed [EST_W-1:0]  pest;
  logic signed [EST_W-1:0]  rest;
  logic [EST_W-1:0]         yaw;
  logic signed [ANG_W-1:0]  pacc;
  logic signed [ANG_W-1:0]  racc;
  logic signed [SUM_W-1:0]  psum;
  logic signed [SUM_W-1:0]  rsum;
  logic signed [YAW_W-1:0]  yaw_sum;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;

  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [EST_W-1:0]  inc;
  logic signed [ACC_W-1:0]  blend_sum;
  logic signed [EST_W-1:0]  blend_sat;
  logic [FRAC_W:0]          beta;
  logic signed [OPND_W-1:0] ax_neg;

  tcf_out_t                 omem [QDEPTH];
  logic [QPTR_W-1:0]        owr;
  logic [QPTR_W-1:0]        ord;
  logic [QCNT_W-1:0]        ocnt;
  logic                     ofull;
  logic                     opush;
  logic                     otake;

  // Saturate a 36-bit shifted blend to the estimate range
  function automatic logic signed [EST_W-1:0] sat_est(input logic signed [ACC_W-FRAC_W-1:0] v);
    logic signed [EST_W-1:0] r;
    if (v[ACC_W-FRAC_W-1:EST_W-1] == '0 || v[ACC_W-FRAC_W-1:EST_W-1] == '1) begin
      r = v[EST_W-1:0];
    end else if (v[ACC_W-FRAC_W-1]) begin
      r = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EST_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign beta      = ALPHA_ONE - {1'b0, cfg.alpha};
  assign inc       = prod[EST_W+7:8];
  assign blend_sum = acc + prod[ACC_W-1:0] + BLEND_RND;
  assign blend_sat = sat_est(blend_sum[ACC_W-1:FRAC_W]);
  assign ax_neg    = -{cur.accel_x[AXIS_W-1], cur.accel_x};
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  // Drive the CORDIC unit
  always_comb begin
    cord_req.start = 1'b0;
    cord_req.y     = '0;
    cord_req.x     = '0;
    unique case (state)
      S_IDLE: begin
        cord_req.start = cmd_valid && !cmd.yaw_reset;
        cord_req.y     = {cmd.accel_y[AXIS_W-1], cmd.accel_y};
        cord_req.x     = {cmd.accel_z[AXIS_W-1], cmd.accel_z};
      end
      S_CORD_P: begin
        cord_req.start = cord_rsp.done;
        cord_req.y     = ax_neg;
        cord_req.x     = {cur.accel_z[AXIS_W-1], cur.accel_z};
      end
      default: begin
      end
    endcase
  end

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_INC_X: begin
        ma = MA_W'(cur.gyro_x);
        mb = {1'b0, cfg.gain};
      end
      S_INC_Y: begin
        ma = MA_W'(cur.gyro_y);
        mb = {1'b0, cfg.gain};
      end
      S_INC_Z: begin
        ma = MA_W'(cur.gyro_z);
        mb = {1'b0, cfg.gain};
      end
      S_PA: begin
        ma = MA_W'(psum);
        mb = signed'(MB_W'(cfg.alpha));
      end
      S_PB: begin
        ma = MA_W'(pacc);
        mb = signed'(MB_W'(beta));
      end
      S_PC: begin
        ma = MA_W'(rsum);
        mb = signed'(MB_W'(cfg.alpha));
      end
      S_RB: begin
        ma = MA_W'(racc);
        mb = signed'(MB_W'(beta));
      end
      default: begin
      end
    endcase
  end

  // Register every product
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Sequence one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pest  <= '0;
      rest  <= '0;
      yaw   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.yaw_reset) begin
              yaw   <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_CORD_P;
            end
          end
        end
        S_CORD_P: begin
          if (cord_rsp.done) begin
            pacc  <= cord_rsp.angle;
            state <= S_CORD_R;
          end
        end
        S_CORD_R: begin
          if (cord_rsp.done) begin
            racc  <= cord_rsp.angle;
            state <= S_INC_X;
          end
        end
        S_INC_X: begin
          state <= S_INC_Y;
        end
        S_INC_Y: begin
          psum  <= SUM_W'(pest) + SUM_W'(inc);
          state <= S_INC_Z;
        end
        S_INC_Z: begin
          rsum  <= SUM_W'(rest) + SUM_W'(inc);
          state <= S_PA;
        end
        S_PA: begin
          yaw_sum <= signed'({2'b00, yaw}) + YAW_W'(inc);
          state   <= S_PB;
        end
        S_PB: begin
          acc <= prod[ACC_W-1:0];
          // wrap yaw once into a full turn
          if (yaw_sum >= YAW_FULL) begin
            yaw <= EST_W'(yaw_sum - YAW_FULL);
          end else if (yaw_sum[YAW_W-1]) begin
            yaw <= EST_W'(yaw_sum + YAW_FULL);
          end else begin
            yaw <= yaw_sum[EST_W-1:0];
          end
          state <= S_PC;
        end
        S_PC: begin
          pest  <= blend_sat;
          state <= S_RB;
        end
        S_RB: begin
          acc   <= prod[ACC_W-1:0];
          state <= S_RC;
        end
        S_RC: begin
          rest  <= blend_sat;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!ofull) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result queue
  assign opush = (state == S_EMIT) && !ofull;
  assign otake = pop && !empty;
  assign ofull = (ocnt == QCNT_W'(QDEPTH));
  assign empty = (ocnt == '0);
  assign result = omem[ord];

  always_ff @(posedge clk) begin
    if (opush) begin
      omem[owr] <= '{pitch_angle: pest[EST_W-1:FRAC_W],
                     roll_angle:  rest[EST_W-1:FRAC_W],
                     yaw_angle:   yaw[EST_W-1:FRAC_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= '0;
      ord  <= '0;
      ocnt <= '0;
    end else begin
      if (opush) begin
        owr <= owr + 1'b1;
      end
      if (otake) begin
        ord <= ord + 1'b1;
      end
      if (opush && !otake) begin
        ocnt <= ocnt + 1'b1;
      end else if (otake && !opush) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tilt_complementary_filter_top.sv =====
// ============================================================================
// tilt_complementary_filter_top: pitch, roll and yaw from inertial samples
// Complementary filter with CORDIC accelerometer angles and gyro integration.
// ============================================================================
// Push a sensor word (req_type 0) or a yaw reset word (req_type 1); each word
// yields one result word with pitch, roll and yaw in 1/128 degree. A sensor
// word runs through the single CORDIC unit, pitch and then roll at one
// micro-rotation per cycle, then the gyro and blend products on one shared
// multiplier. A yaw reset word skips both and clears yaw. Two-entry queues on
// the input and the result side let the feeder and the consumer stall on their
// own. Write blend_alpha (index 0) and gyro_step_gain (index 1) only while
// no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module tilt_complementary_filter_top import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  tcf_in_t          sample,
  output logic             empty,
  input  logic             pop,
  output tcf_out_t         result,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  tcf_cfg_t      cfg;
  logic          cmd_valid;
  tcf_cmd_t      cmd;
  logic          cmd_pop;
  tcf_cord_req_t cord_req;
  tcf_cord_rsp_t cord_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= ALPHA_RST;
      cfg.gain  <= GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ALPHA: cfg.alpha <= cfg_data[15:0];
        CFG_GAIN:  cfg.gain  <= cfg_data[23:0];
      endcase
    end
  end

  tcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  tcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cord_req  (cord_req),
    .cord_rsp  (cord_rsp),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // The CORDIC unit is never restarted while it is iterating
  a_cord_idle_start: assert property (@(posedge clk) disable iff (rst)
    cord_req.start |-> !cord_rsp.busy)
    else $error("CORDIC started while busy");

  // A start always puts the CORDIC unit to work
  a_cord_runs: assert property (@(posedge clk) disable iff (rst)
    cord_req.start |=> cord_rsp.busy)
    else $error("CORDIC did not run after start");

  // Completion only follows iteration
  a_cord_done: assert property (@(posedge clk) disable iff (rst)
    cord_rsp.done |-> $past(cord_rsp.busy))
    else $error("CORDIC done without iteration");

  // Queued yaw stays within one turn
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.yaw_angle < YAW_TURN))
    else $error("yaw out of range");

endmodule

`default_nettype wire

// ===== sim/tb_tilt_complementary_filter_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_tilt_complementary_filter_top: self-checking bench for the tilt filter
// Pushes sensor and yaw reset words, predicts pitch, roll and yaw with a
// behavioral CORDIC, blend and heading integrator, and checks each popped
// result word in order under several blend and gyro gain settings.
// ============================================================================

module tb_tilt_complementary_filter_top;
  import tcf_pkg::*;

  localparam int ROTATIONS   = 16;
  localparam int SETTLE      = 2 * ROTATIONS + 16;
  localparam int DRAIN_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  localparam longint QUARTER_TURN = 64'sd754974720;
  localparam longint FULL_TURN    = 64'sd3019898880;
  localparam longint EST_MAX      = 64'sd2147483647;
  localparam longint EST_MIN      = -64'sd2147483648;

  localparam logic signed [15:0] AXIS_MAX  = 16'sh7fff;
  localparam logic signed [15:0] AXIS_MIN  = 16'sh8000;
  localparam logic signed [15:0] ONE_G     = 16'sd16384;
  localparam logic signed [15:0] NEG_G     = -16'sd16384;
  localparam logic signed [15:0] ODD_BITS  = 16'sh5555;
  localparam logic signed [15:0] EVEN_BITS = 16'shaaaa;

  // atan(2^-i) in Q16 of 1/128 degree
  localparam longint ARC_STEP [24] = '{
    377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
    7509261, 3754860, 1877459, 938733, 469367, 234683,
    117342, 58671, 29335, 14668, 7334, 3667,
    1833, 917, 458, 229, 115, 57
  };

  typedef struct packed {
    logic     typed;
    tcf_in_t  word;
    tcf_out_t want;
  } stim_row_t;

  // Directed words; typed rows carry a result known by inspection
  localparam int N_DIRECTED = 18;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // all-zero sample: both atan2 operands zero
    '{1'b1, '{REQ_SAMPLE, '0, '0, '0, '0, '0, '0}, '0},
    // yaw reset with busy sensor fields, which are ignored
    '{1'b1, '{REQ_YAW_RESET, AXIS_MAX, AXIS_MIN, ONE_G, AXIS_MAX, AXIS_MAX, AXIS_MAX}, '0},
    // level and still
    '{1'b1, '{REQ_SAMPLE, '0, '0, ONE_G, '0, '0, '0}, '0},
    // upside down with zero lateral count
    '{1'b0, '{REQ_SAMPLE, '0, '0, NEG_G, '0, '0, '0}, '0},
    '{1'b0, '{REQ_SAMPLE, '0, '0, AXIS_MIN, '0, '0, '0}, '0},
    '{1'b0, '{REQ_SAMPLE, AXIS_MAX, AXIS_MIN, '0, '0, '0, '0}, '0},
    '{1'b0, '{REQ_SAMPLE, AXIS_MIN, AXIS_MAX, AXIS_MAX, '0, '0, '0}, '0},
    '{1'b0, '{REQ_SAMPLE, 16'sd1, '1, AXIS_MIN, '0, '0, '0}, '0},
    // full-scale rates both ways; yaw crosses zero
    '{1'b0, '{REQ_SAMPLE, '0, '0, ONE_G, AXIS_MAX, AXIS_MAX, AXIS_MAX}, '0},
    '{1'b0, '{REQ_SAMPLE, '0, '0, ONE_G, AXIS_MIN, AXIS_MIN, AXIS_MIN}, '0},
    '{1'b0, '{REQ_SAMPLE, '1, '1, '1, '1, '1, '1}, '0},
    '{1'b0, '{REQ_SAMPLE, ODD_BITS, ODD_BITS, ODD_BITS, ODD_BITS, ODD_BITS, ODD_BITS}, '0},
    '{1'b0, '{REQ_SAMPLE, EVEN_BITS, EVEN_BITS, EVEN_BITS, EVEN_BITS, EVEN_BITS,
              EVEN_BITS}, '0},
    // yaw reset with pitch and roll held
    '{1'b0, '{REQ_YAW_RESET, '0, '0, '0, '0, '0, '0}, '0},
    // negative turn from zero wraps to just under a full turn
    '{1'b0, '{REQ_SAMPLE, '0, '0, '0, '0, '0, AXIS_MIN}, '0},
    '{1'b0, '{REQ_SAMPLE, AXIS_MIN, AXIS_MIN, AXIS_MIN, 16'sd1, 16'sd1, 16'sd1}, '0},
    '{1'b0, '{REQ_SAMPLE, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MAX, '0}, '0},
    '{1'b0, '{REQ_YAW_RESET, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN,
              AXIS_MIN}, '0}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  tcf_in_t          sample = '0;
  logic             empty;
  logic             pop = 1'b0;
  tcf_out_t         result;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = CFG_ALPHA;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predicted filter state and settings
  logic signed [31:0] pitch_est = '0;
  logic signed [31:0] roll_est = '0;
  logic [31:0]        heading = '0;
  int                 alpha_set = int'(ALPHA_RST);
  int                 gain_set = int'(GAIN_RST);

  tcf_out_t angles_due[$];
  bit       calm = 1'b0;
  int       stall_left = 0;
  int       errors = 0;
  int       words_checked = 0;
  int       samples_sent = 0;
  int       resets_sent = 0;
  int       settings_used = 1;

  tilt_complementary_filter_top #(.CORDIC_STEPS(ROTATIONS)) dut (
    .clk,
    .rst,
    .push,
    .full,
    .sample,
    .empty,
    .pop,
    .result,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("tb_tilt_complementary_filter_top NOT OK");
    $finish;
  end

  task automatic flag_error(input string what, input longint got, input longint want);
    if (errors < PRINT_LIMIT) begin
      $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // atan2(lat, fwd) in Q16 of 1/128 degree by vectoring CORDIC
  function automatic longint vector_angle(input longint lat, input longint fwd);
    longint x, y, z, t, xs, ys;
    int i;
    if (lat == 0 && fwd == 0) return 0;
    x = fwd * 65536;
    y = lat * 65536;
    z = 0;
    // fold the left half-plane onto the right
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += ARC_STEP[i];
      end else if (y < 0) begin
        x -= ys;
        y += xs;
        z -= ARC_STEP[i];
      end
    end
    return z;
  endfunction

  // Mix the gyro-propagated estimate with the accelerometer angle, then clamp
  function automatic logic signed [31:0] blend_estimate(input logic signed [31:0] est,
                                                        input longint gyro_inc,
                                                        input longint accel_ang);
    longint weight, total;
    weight = longint'(alpha_set);
    total = weight * (longint'(est) + gyro_inc) + (64'sd65536 - weight) * accel_ang
            + 64'sd32768;
    total = total >>> 16;
    if (total > EST_MAX) total = EST_MAX;
    else if (total < EST_MIN) total = EST_MIN;
    return total[31:0];
  endfunction

  // Advance the predicted state by one word and return its result word
  function automatic tcf_out_t advance_filter(input tcf_in_t w);
    longint gain, turned;
    tcf_out_t angles;
    gain = longint'(gain_set);
    if (w.req_type == REQ_YAW_RESET) begin
      heading = '0;
    end else begin
      pitch_est = blend_estimate(pitch_est, (longint'($signed(w.gyro_x)) * gain) >>> 8,
                                 vector_angle(longint'($signed(w.accel_y)),
                                              longint'($signed(w.accel_z))));
      roll_est = blend_estimate(roll_est, (longint'($signed(w.gyro_y)) * gain) >>> 8,
                                vector_angle(-longint'($signed(w.accel_x)),
                                             longint'($signed(w.accel_z))));
      turned = longint'({32'd0, heading}) + ((longint'($signed(w.gyro_z)) * gain) >>> 8);
      // one wrap always lands inside a full turn
      if (turned >= FULL_TURN) turned -= FULL_TURN;
      else if (turned < 0) turned += FULL_TURN;
      heading = turned[31:0];
    end
    angles.pitch_angle = pitch_est[31:16];
    angles.roll_angle  = roll_est[31:16];
    angles.yaw_angle   = heading[31:16];
    return angles;
  endfunction

  // Mostly near-gravity and small values, with extremes and raw noise
  function automatic logic signed [15:0] pick_axis();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return AXIS_MIN;
        1:       return AXIS_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 4) return 16'(int'($urandom_range(0, 512)) - 256);
    if (pick < 7) return 16'($urandom);
    return 16'(int'($urandom_range(0, 1024)) - 512 +
               (($urandom_range(0, 1) == 1) ? 16384 : -16384));
  endfunction

  function automatic tcf_in_t random_sample();
    tcf_in_t w;
    w.req_type = ($urandom_range(0, 15) == 0) ? REQ_YAW_RESET : REQ_SAMPLE;
    w.accel_x  = pick_axis();
    w.accel_y  = pick_axis();
    w.accel_z  = pick_axis();
    w.gyro_x   = pick_axis();
    w.gyro_y   = pick_axis();
    w.gyro_z   = pick_axis();
    return w;
  endfunction

  // Check one popped word against the oldest prediction
  task automatic check_word(input tcf_out_t got);
    tcf_out_t want;
    if (angles_due.size() == 0) begin
      flag_error("result word with nothing pending, yaw", got.yaw_angle, 0);
      return;
    end
    want = angles_due.pop_front();
    if (got.pitch_angle !== want.pitch_angle) begin
      flag_error("pitch_angle", got.pitch_angle, want.pitch_angle);
    end
    if (got.roll_angle !== want.roll_angle) begin
      flag_error("roll_angle", got.roll_angle, want.roll_angle);
    end
    if (got.yaw_angle !== want.yaw_angle) begin
      flag_error("yaw_angle", got.yaw_angle, want.yaw_angle);
    end
    words_checked++;
  endtask

  // Result side: take words, stall in random bursts unless calm
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_word(result);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one word, hold until accepted, then record its prediction
  task automatic send_word(input tcf_in_t w, input logic typed, input tcf_out_t want);
    tcf_out_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push   <= 1'b1;
    sample <= w;
    do @(posedge clk); while (full);
    predicted = advance_filter(w);
    angles_due.push_back(typed ? want : predicted);
    if (w.req_type == REQ_YAW_RESET) resets_sent++;
    else samples_sent++;
  endtask

  // Wait for every pending result, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    while (angles_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (angles_due.size() != 0) begin
      flag_error("result words never arrived", angles_due.size(), 0);
      angles_due.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both filter registers on consecutive cycles
  task automatic program_filter(input int alpha, input int gain);
    alpha_set = alpha & 32'hffff;
    gain_set  = gain & 32'hffffff;
    cfg_write <= 1'b1;
    cfg_index <= CFG_ALPHA;
    cfg_data  <= CFG_W'(alpha_set);
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_data  <= CFG_W'(gain_set);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int alpha, input int gain, input int count, input bit quiet);
    int n;
    drain();
    program_filter(alpha, gain);
    calm = quiet;
    for (n = 0; n < count; n++) send_word(random_sample(), 1'b0, '0);
    push <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset settings
    for (i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
    end
    push <= 1'b0;

    // full gyro weight and gain drive saturation and yaw wrap
    run_phase(32'hffff, 32'hffffff, 80, 1'b0);
    // accelerometer only, gyro ignored
    run_phase(0, 0, 60, 1'b0);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 16777215), 80, 1'b0);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 400000), 80, 1'b1);
    run_phase(1, 1, 60, 1'b0);
    // back to the reset settings with no idling
    run_phase(int'(ALPHA_RST), int'(GAIN_RST), 120, 1'b1);
    drain();

    $display("Sent %0d sensor words and %0d yaw resets under %0d filter settings;",
             samples_sent, resets_sent, settings_used);
    $display("checked %0d result words with %0d mismatches.", words_checked, errors);
    if (errors == 0) begin
      $display("tb_tilt_complementary_filter_top OK");
    end else begin
      $display("tb_tilt_complementary_filter_top NOT OK");
    end
    $finish;
  end

endmodule
